@@ rtl/core/dsh_pkg.sv @@
package dsh_pkg;

  // command codes on req_type
  typedef enum logic [1:0] {
    REQ_STEP   = 2'd0,
    REQ_CUT    = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_RESEND = 2'd3
  } req_e;

  // ir-cut mode codes on cut_mode, anything else clears
  localparam logic [1:0] CUT_DRIVE_A = 2'd1;
  localparam logic [1:0] CUT_DRIVE_B = 2'd2;

  localparam int unsigned STATUS_W = 16;

  // ir-cut drive words and the mask kept on a clear
  localparam logic [STATUS_W-1:0] IRCUT_A    = 16'h00B0;
  localparam logic [STATUS_W-1:0] IRCUT_B    = 16'h0070;
  localparam logic [STATUS_W-1:0] IRCUT_KEEP = 16'hFF00;

  // status bits 3..0 are never set, so the stored status drops them
  localparam int unsigned STAT_LO = 4;
  localparam int unsigned STAT_W  = STATUS_W - STAT_LO;

  // half-step coil nibble for one motor
  function automatic logic [3:0] coil_nibble(input logic [2:0] phase);
    logic [3:0] nib;
    unique case (phase)
      3'd0:    nib = 4'h8;
      3'd1:    nib = 4'h9;
      3'd2:    nib = 4'h1;
      3'd3:    nib = 4'h3;
      3'd4:    nib = 4'h2;
      3'd5:    nib = 4'h6;
      3'd6:    nib = 4'h4;
      default: nib = 4'hC;
    endcase
    return nib;
  endfunction

endpackage

@@ rtl/core/dsh_cmd.sv @@
module dsh_cmd #(
  parameter int unsigned FRAME_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  dsh_pkg::req_e         req_i,
  input  logic                  motor_i,
  input  logic [2:0]            phase_i,
  input  logic [1:0]            mode_i,
  input  logic                  take_i,
  output logic                  pend_vld_o,
  output logic [FRAME_BITS-1:0] pend_word_o
);
  import dsh_pkg::*;

  logic [STAT_W-1:0]     status_q, status_d;
  logic [3:0]            ircut_q, ircut_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [FRAME_BITS-1:0] pend_q, pend_d;
  logic [STATUS_W-1:0]   pattern;
  logic [STATUS_W-1:0]   step_word;
  logic [STATUS_W-1:0]   send_word;
  logic                  sends;

  always_comb begin
    logic [3:0] nib;
    nib = coil_nibble(phase_i);
    pattern = motor_i ? {nib, 12'h000} : {4'h0, nib, 8'h00};
  end

  assign step_word = pattern | {8'h00, ircut_q, 4'h0};

  always_comb begin
    status_d  = status_q;
    ircut_d   = ircut_q;
    send_word = '0;
    sends     = 1'b0;
    if (acc_i) begin
      unique case (req_i)
        REQ_STEP: begin
          status_d  = step_word[STATUS_W-1:STAT_LO];
          send_word = step_word;
          sends     = 1'b1;
        end
        REQ_CUT: begin
          if (mode_i == CUT_DRIVE_A) begin
            ircut_d  = IRCUT_A[7:4];
            status_d = status_q | IRCUT_A[STATUS_W-1:STAT_LO];
          end else if (mode_i == CUT_DRIVE_B) begin
            ircut_d  = IRCUT_B[7:4];
            status_d = status_q | IRCUT_B[STATUS_W-1:STAT_LO];
          end else begin
            ircut_d  = '0;
            status_d = status_q & IRCUT_KEEP[STATUS_W-1:STAT_LO];
          end
        end
        REQ_STOP: begin
          sends = 1'b1;
        end
        REQ_RESEND: begin
          send_word = {status_q, {STAT_LO{1'b0}}};
          sends     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pend_vld_d = pend_vld_q & ~take_i;
    pend_d     = pend_q;
    if (sends) begin
      pend_vld_d = 1'b1;
      pend_d     = send_word[STATUS_W-1 -: FRAME_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= '0;
      ircut_q    <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      status_q   <= status_d;
      ircut_q    <= ircut_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  assign pend_vld_o  = pend_vld_q;
  assign pend_word_o = pend_q;

  // a waiting frame is never overwritten before the serializer takes it
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q && !take_i |=> pend_vld_q && $stable(pend_q))
    else $error("pending frame overwritten");

  // ir-cut nibble only ever holds clear, drive A or drive B
  a_ircut_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ircut_q == 4'h0 || ircut_q == IRCUT_A[7:4] || ircut_q == IRCUT_B[7:4])
    else $error("bad ir-cut bits");

endmodule

@@ rtl/core/dsh_ser.sv @@
module dsh_ser #(
  parameter int unsigned FRAME_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pend_vld_i,
  input  logic [FRAME_BITS-1:0] pend_word_i,
  output logic                  take_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  serial_bit_o,
  output logic                  frame_last_o
);
  localparam int unsigned CntW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(FRAME_BITS - 1);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [FRAME_BITS-1:0] sh_q, sh_d;
  logic                  last;
  logic                  out_acc;

  assign last    = (cnt_q == LastIdx);
  assign out_acc = busy_q & ~out_stall_i;
  assign take_o  = pend_vld_i & (~busy_q | (out_acc & last));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    if (take_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = pend_word_i;
    end else if (out_acc) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        sh_d  = sh_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign out_valid_o  = busy_q;
  assign serial_bit_o = sh_q[FRAME_BITS-1];
  assign frame_last_o = last;

  // bit counter stays inside the frame
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= LastIdx)
    else $error("bit counter past frame end");

  // after the final bit goes out with nothing waiting, the serializer idles
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last && !pend_vld_i |=> !busy_q)
    else $error("serializer ran past frame end");

endmodule

@@ rtl/core/dual_stepper_halfstep_serializer_core.sv @@
// Command front end and serializer for a two-motor four-phase stepper driver
// with an ir-cut output. Each accepted item is decoded combinationally: a step
// command builds the half-step coil pattern of the chosen motor, ors in the
// kept ir-cut bits and stores it as the new driver status; an ir-cut command
// sets or clears the ir-cut bits and updates the status without sending; a
// stop command queues an all-zero frame; a resend queues the stored status.
// A sending command emits the top FRAME_BITS status bits, msb first, one
// serial bit per result item, with frame_last_o high on the final bit.
// Rate: one result item per cycle while the output is not stalled, so a
// sending command occupies the shift register for FRAME_BITS result items
// (10 by default); one decoded frame waits in a holding register, so the
// next item is taken while the current frame is still shifting, and ir-cut
// commands are taken every cycle as long as the holding register is free.
// An accepted frame passes the holding register, then the shift register.
module dual_stepper_halfstep_serializer_core #(
  parameter int unsigned FRAME_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic       motor_sel_i,
  input  logic [2:0] step_phase_i,
  input  logic [1:0] cut_mode_i,
  // serial bit items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       serial_bit_o,
  output logic       frame_last_o
);
  import dsh_pkg::*;

  logic                  in_acc;
  logic                  pend_vld;
  logic                  take;
  logic [FRAME_BITS-1:0] pend_word;

  // hold off new items only while a decoded frame waits and cannot move on
  assign in_stall_o = pend_vld & ~take;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // decode, status and ir-cut state, holding register for one frame
  dsh_cmd #(
    .FRAME_BITS (FRAME_BITS)
  ) u_cmd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .req_i       (req_e'(req_type_i)),
    .motor_i     (motor_sel_i),
    .phase_i     (step_phase_i),
    .mode_i      (cut_mode_i),
    .take_i      (take),
    .pend_vld_o  (pend_vld),
    .pend_word_o (pend_word)
  );

  // frame shift register and bit counter
  dsh_ser #(
    .FRAME_BITS (FRAME_BITS)
  ) u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_vld_i   (pend_vld),
    .pend_word_i  (pend_word),
    .take_o       (take),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .serial_bit_o (serial_bit_o),
    .frame_last_o (frame_last_o)
  );

endmodule
